>>> rtl/gord_pkg.sv
package gord_pkg;
  localparam int MAP_SIDE_DEF   = 64;
  localparam int MAX_RADIUS_DEF = 15;
  localparam int CFG_W          = 7;
  localparam logic signed [7:0] FREE = 8'sd0;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_RUN   = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_ROWS   = 2'd0,
    REG_COLS   = 2'd1,
    REG_RADIUS = 2'd2,
    REG_NONE   = 2'd3
  } reg_idx_t;

  // Controller commands to the datapath.
  typedef struct packed {
    logic clr_start;   // load the clear sweep counter
    logic clr_step;    // clear one result cell
    logic ring_init;   // reset the circle walker and the scan position
    logic ring_step;   // advance the circle walker by one point
    logic oct_step;    // apply one of the eight mirrored offsets
    logic scan_next;   // move to the next source cell, restart the ring
    logic rd_src;      // read source cell at the scan position
    logic rd_dst;      // read result cell at the current target
    logic wr_dst;      // conditional update of the target result cell
  } dp_cmd_t;

  // Datapath status back to the controller.
  typedef struct packed {
    logic clr_done;
    logic ring_done;   // walker has finished the octant
    logic scan_done;   // last source cell visited
    logic src_free;    // scanned source cell is zero
    logic area_empty;
  } dp_sts_t;
endpackage

>>> rtl/gord_ctrl.sv
module gord_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output gord_pkg::dp_cmd_t cmd,
  input  gord_pkg::dp_sts_t sts,
  output logic              busy
);
  import gord_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CLR   = 8'b0000_0010,
    S_SRC   = 8'b0000_0100,
    S_CHK   = 8'b0000_1000,
    S_OCT   = 8'b0001_0000,
    S_UPD   = 8'b0010_0000,
    S_NEXT  = 8'b0100_0000,
    S_WALK  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic [2:0] oct_r, oct_nxt;
  logic boot_r, boot_nxt;

  // Next-state logic. Each ring offset is read in S_OCT, then updated in S_UPD.
  // The clear sweep after reset returns to idle without a scan.
  always_comb begin
    state_nxt = state_r;
    oct_nxt   = oct_r;
    boot_nxt  = boot_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.clr_start = 1'b1;
          state_nxt = S_CLR;
        end
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) begin
          cmd.ring_init = 1'b1;
          boot_nxt  = 1'b0;
          state_nxt = (boot_r || sts.area_empty) ? S_IDLE : S_SRC;
        end
      end
      S_SRC: begin
        cmd.rd_src = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        oct_nxt = '0;
        state_nxt = sts.src_free ? S_NEXT : S_OCT;
      end
      S_OCT: begin
        cmd.rd_dst = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.wr_dst   = 1'b1;
        cmd.oct_step = 1'b1;
        oct_nxt = oct_r + 3'd1;
        state_nxt = (oct_r == 3'd7) ? S_WALK : S_OCT;
      end
      S_WALK: begin
        oct_nxt = '0;
        if (sts.ring_done) state_nxt = S_NEXT;
        else begin
          cmd.ring_step = 1'b1;
          state_nxt = S_OCT;
        end
      end
      S_NEXT: begin
        if (sts.scan_done) state_nxt = S_IDLE;
        else begin
          cmd.scan_next = 1'b1;
          state_nxt = S_SRC;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      oct_r   <= '0;
      boot_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      oct_r   <= oct_nxt;
      boot_r  <= boot_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);
endmodule

>>> rtl/gord_dp.sv
module gord_dp #(
  parameter int MAP_SIDE   = gord_pkg::MAP_SIDE_DEF,
  parameter int MAX_RADIUS = gord_pkg::MAX_RADIUS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  gord_pkg::dp_cmd_t        cmd,
  output gord_pkg::dp_sts_t        sts,
  input  logic [gord_pkg::CFG_W-1:0] rows_cfg,
  input  logic [gord_pkg::CFG_W-1:0] cols_cfg,
  input  logic [3:0]               radius_cfg,
  input  logic                     src_we,
  input  logic [5:0]               wr_row,
  input  logic [5:0]               wr_col,
  input  logic signed [7:0]        wr_val,
  input  logic                     rd_en,
  input  logic [5:0]               rd_row,
  input  logic [5:0]               rd_col,
  output logic signed [7:0]        rd_val
);
  import gord_pkg::*;

  localparam int AW   = $clog2(MAP_SIDE);
  localparam int CW   = AW + 1;
  localparam int DEP  = 1 << (2 * AW);
  localparam int RW   = $clog2(MAX_RADIUS + 1) + 1;
  localparam int EW   = RW + 3;
  localparam int TW   = ((CW > RW) ? CW : RW) + 2;

  logic signed [7:0] src_mem [DEP];
  logic signed [7:0] dst_mem [DEP];

  // Effective area and radius, saturated to the array side and to MAX_RADIUS.
  logic [CW-1:0] rows_eff, cols_eff;
  logic [RW-1:0] rad_eff;
  always_comb begin
    rows_eff = (32'(rows_cfg) > MAP_SIDE) ? CW'(MAP_SIDE) : CW'(rows_cfg);
    cols_eff = (32'(cols_cfg) > MAP_SIDE) ? CW'(MAP_SIDE) : CW'(cols_cfg);
    rad_eff  = (32'(radius_cfg) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(radius_cfg);
  end

  // Clear sweep, scan position and the circle walker.
  logic [2*AW:0] clr_r;
  logic [AW-1:0] sr_r, sc_r;
  logic signed [RW:0] rx_r, ry_r;
  logic signed [EW-1:0] err_r, ddx_r, ddy_r;
  logic first_r;          // axis point stage, before the walk begins
  logic [2:0] oct_r;
  logic signed [7:0] v_r, d_r;
  logic [2*AW-1:0] tidx_r;
  logic tin_r;
  logic skip;

  // Offset for the current mirror. The axis stage has four distinct points.
  logic signed [RW:0] di, dj;
  always_comb begin
    di = '0; dj = '0; skip = 1'b0;
    if (first_r) begin
      case (oct_r[1:0])
        2'd0: begin di = '0;     dj = ry_r;  end
        2'd1: begin di = '0;     dj = -ry_r; end
        2'd2: begin di = ry_r;   dj = '0;    end
        default: begin di = -ry_r; dj = '0;  end
      endcase
      skip = oct_r[2];
    end else begin
      case (oct_r)
        3'd0: begin di = rx_r;  dj = ry_r;  end
        3'd1: begin di = -rx_r; dj = ry_r;  end
        3'd2: begin di = rx_r;  dj = -ry_r; end
        3'd3: begin di = -rx_r; dj = -ry_r; end
        3'd4: begin di = ry_r;  dj = rx_r;  end
        3'd5: begin di = -ry_r; dj = rx_r;  end
        3'd6: begin di = ry_r;  dj = -rx_r; end
        default: begin di = -ry_r; dj = -rx_r; end
      endcase
      skip = oct_r[2] && (rx_r == ry_r);
    end
  end

  logic signed [TW-1:0] tr, tc;
  logic tin;
  always_comb begin
    tr  = TW'($signed({1'b0, sr_r})) + TW'(di);
    tc  = TW'($signed({1'b0, sc_r})) + TW'(dj);
    tin = !skip && (tr >= 0) && (tc >= 0) &&
          (tr < TW'($signed({1'b0, rows_eff}))) && (tc < TW'($signed({1'b0, cols_eff})));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r   <= '0;
      sr_r    <= '0; sc_r <= '0;
      rx_r    <= '0; ry_r <= '0;
      err_r   <= '0; ddx_r <= '0; ddy_r <= '0;
      first_r <= 1'b1;
      oct_r   <= '0;
      tin_r   <= 1'b0;
    end else begin
      if (cmd.clr_start) clr_r <= '0;
      else if (cmd.clr_step) clr_r <= clr_r + 1'b1;
      if (cmd.ring_init || cmd.scan_next) begin
        rx_r    <= '0;
        ry_r    <= (RW+1)'(rad_eff);
        err_r   <= EW'(1) - EW'(rad_eff);
        ddx_r   <= EW'(1);
        ddy_r   <= -(EW'(rad_eff) <<< 1);
        first_r <= 1'b1;
        oct_r   <= '0;
      end
      if (cmd.ring_init) begin
        sr_r <= '0; sc_r <= '0;
      end else if (cmd.scan_next) begin
        if (32'(sc_r) + 1 >= 32'(cols_eff)) begin
          sc_r <= '0;
          sr_r <= sr_r + 1'b1;
        end else sc_r <= sc_r + 1'b1;
      end
      if (cmd.rd_dst) begin
        tin_r  <= tin;
        tidx_r <= {tr[AW-1:0], tc[AW-1:0]};
      end
      if (cmd.oct_step) oct_r <= oct_r + 3'd1;
      // One midpoint step on the octant walker.
      if (cmd.ring_step) begin
        first_r <= 1'b0;
        if (err_r >= 0) begin
          ry_r  <= ry_r - 1'b1;
          ddy_r <= ddy_r + EW'(2);
          err_r <= err_r + ddy_r + EW'(2) + ddx_r + EW'(2);
        end else begin
          err_r <= err_r + ddx_r + EW'(2);
        end
        rx_r  <= rx_r + 1'b1;
        ddx_r <= ddx_r + EW'(2);
      end
    end
  end

  // Memories: source written by the port, result written by clear or update.
  logic [2*AW-1:0] waddr;
  always_comb waddr = {AW'(wr_row), AW'(wr_col)};
  always_ff @(posedge clk) begin
    if (src_we) src_mem[waddr] <= wr_val;
    if (cmd.rd_src) v_r <= src_mem[{sr_r, sc_r}];
  end
  always_ff @(posedge clk) begin
    if (cmd.clr_step) dst_mem[clr_r[2*AW-1:0]] <= FREE;
    else if (cmd.wr_dst && tin_r && (v_r > d_r)) dst_mem[tidx_r] <= v_r;
    if (cmd.rd_dst) d_r <= dst_mem[{tr[AW-1:0], tc[AW-1:0]}];
    if (rd_en) rd_val <= dst_mem[{AW'(rd_row), AW'(rd_col)}];
  end

  always_comb begin
    sts.clr_done   = (32'(clr_r) == DEP - 1);
    sts.ring_done  = first_r ? (ry_r == 0) : !(rx_r < ry_r);
    sts.scan_done  = (32'(sr_r) + 1 >= 32'(rows_eff)) && (32'(sc_r) + 1 >= 32'(cols_eff));
    sts.src_free   = (v_r == FREE);
    sts.area_empty = (rows_eff == '0) || (cols_eff == '0);
  end
endmodule

>>> rtl/grid_obstacle_ring_dilation_core.sv
// A cell write is registered into the source memory; a read result is valid the cycle after its transfer.
// Throughput: one write or read transfer per cycle while no run is busy and the result side keeps up.
// A run stalls the input until it is done: it clears the result memory, then reads and checks
// each area cell; for each nonzero cell it handles every ring point as eight mirror slots, each
// a read then an update, and a walker step; the points are one axis point and ~0.7*r steps.
// Reset: synchronous active low; rows 40, cols 40, radius 2, then a result clear.
module grid_obstacle_ring_dilation_core #(
  parameter int MAP_SIDE   = gord_pkg::MAP_SIDE_DEF,
  parameter int MAX_RADIUS = gord_pkg::MAX_RADIUS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_op,
  input  logic [5:0]        in_row,
  input  logic [5:0]        in_col,
  input  logic signed [7:0] in_cell_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic signed [7:0] out_result_value,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [gord_pkg::CFG_W-1:0] cfg_data
);
  import gord_pkg::*;

  logic [CFG_W-1:0] rows_r, cols_r;
  logic [3:0] rad_r;
  logic busy;
  dp_cmd_t cmd;
  dp_sts_t sts;
  logic acc, rd_en, in_grid;
  logic signed [7:0] rd_val;
  logic pend_r, zero_r;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= CFG_W'(40);
      cols_r <= CFG_W'(40);
      rad_r  <= 4'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROWS:   rows_r <= cfg_data;
        REG_COLS:   cols_r <= cfg_data;
        REG_RADIUS: rad_r  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // An input transfer waits for a run to finish and for the output register to drain.
  assign in_stall = busy || (pend_r && out_stall);
  assign acc      = in_valid && !in_stall;
  assign in_grid  = (32'(in_row) < MAP_SIDE) && (32'(in_col) < MAP_SIDE);
  assign rd_en    = acc && (in_op == OP_READ);

  gord_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(acc && (in_op == OP_RUN)),
    .cmd(cmd), .sts(sts), .busy(busy)
  );

  gord_dp #(.MAP_SIDE(MAP_SIDE), .MAX_RADIUS(MAX_RADIUS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .rows_cfg(rows_r), .cols_cfg(cols_r), .radius_cfg(rad_r),
    .src_we(acc && (in_op == OP_WRITE) && in_grid),
    .wr_row(in_row), .wr_col(in_col), .wr_val(in_cell_value),
    .rd_en(rd_en), .rd_row(in_row), .rd_col(in_col), .rd_val(rd_val)
  );

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
      zero_r <= 1'b0;
    end else begin
      if (rd_en) begin
        pend_r <= 1'b1;
        zero_r <= !in_grid;
      end else if (!out_stall) pend_r <= 1'b0;
    end
  end

  assign out_valid        = pend_r;
  assign out_result_value = zero_r ? FREE : rd_val;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !acc) else $error("item accepted during a run");
  a_read_gives_out: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |=> out_valid) else $error("read produced no result");
  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_result_value)))
    else $error("stalled result changed");
endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import gord_pkg::*;

  localparam int SIDE      = 64;
  localparam int CYC_LIMIT = 40_000_000;
  localparam int HOLD_LEN  = 400;
  localparam int N_ITEMS   = 1900;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [1:0]        in_op;
  logic [5:0]        in_row;
  logic [5:0]        in_col;
  logic signed [7:0] in_cell_value;
  logic              out_valid;
  logic              out_stall;
  logic signed [7:0] out_result_value;
  logic              cfg_we;
  logic [1:0]        cfg_index;
  logic [CFG_W-1:0]  cfg_data;

  grid_obstacle_ring_dilation_core uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_op(in_op),
    .in_row(in_row),
    .in_col(in_col),
    .in_cell_value(in_cell_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_result_value(out_result_value),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Shadow copy of the grid, the dilated map and the registers.
  logic signed [7:0] grid_src [SIDE*SIDE];
  logic signed [7:0] grid_dil [SIDE*SIDE];
  bit                cell_written [SIDE*SIDE];
  int unsigned       rows_reg;
  int unsigned       cols_reg;
  int unsigned       radius_reg;

  logic signed [7:0] pending_values [$];
  int                errors;
  int                n_items;
  int                tx_idle_pct;
  int                rx_idle_pct;
  int                hold_req;
  int                hold_seen;
  int                hold_left;
  longint            cycles;

  typedef struct {
    op_t               op;
    logic [5:0]        row;
    logic [5:0]        col;
    logic signed [7:0] value;
    bit                known;
    logic signed [7:0] want;
  } dir_row_t;

  dir_row_t dir_rows [] = '{
    '{OP_READ,  6'd0,  6'd0,  8'sd0,    1'b1, 8'sd0},
    '{OP_READ,  6'd63, 6'd63, -8'sd1,   1'b1, 8'sd0},
    '{OP_NONE,  6'd63, 6'd63, -8'sd1,   1'b0, 8'sd0},
    '{OP_WRITE, 6'd63, 6'd63, -8'sd128, 1'b0, 8'sd0},
    '{OP_WRITE, 6'd0,  6'd0,  8'sd127,  1'b0, 8'sd0},
    '{OP_WRITE, 6'd63, 6'd0,  8'sd100,  1'b0, 8'sd0},
    '{OP_WRITE, 6'd0,  6'd63, -8'sd1,   1'b0, 8'sd0},
    '{OP_READ,  6'd63, 6'd0,  8'sd0,    1'b1, 8'sd0},
    '{OP_NONE,  6'd0,  6'd0,  8'sd0,    1'b0, 8'sd0},
    '{OP_READ,  6'd31, 6'd32, 8'sd85,   1'b1, 8'sd0}
  };

  // Clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Cycle limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver stall, with a long hold-off on request.
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Compare each result transfer with the oldest expected value.
  always @(posedge clk) begin
    logic signed [7:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_values.size() == 0) begin
        $error("result_value: unexpected transfer, actual %0d", out_result_value);
        errors++;
      end else begin
        want = pending_values.pop_front();
        if (out_result_value !== want) begin
          $error("result_value: expected %0d, actual %0d", want, out_result_value);
          errors++;
        end
      end
    end
  end

  function automatic int unsigned eff_rows();
    return (rows_reg > SIDE) ? SIDE : rows_reg;
  endfunction

  function automatic int unsigned eff_cols();
    return (cols_reg > SIDE) ? SIDE : cols_reg;
  endfunction

  // Grayscale dilation with the midpoint circle perimeter as stencil.
  task automatic dilate_grid();
    int off_r [$];
    int off_c [$];
    int rad, x, y, err, ddx, ddy, nr, nc, tr, tc, t;
    logic signed [7:0] v;
    nr = eff_rows();
    nc = eff_cols();
    rad = (radius_reg > 15) ? 15 : radius_reg;
    foreach (grid_dil[i]) grid_dil[i] = 8'sd0;
    ddx = 1;
    ddy = -2 * rad;
    err = 1 - rad;
    x = 0;
    y = rad;
    off_r = '{0, 0, rad, -rad};
    off_c = '{rad, -rad, 0, 0};
    while (x < y) begin
      if (err >= 0) begin
        y--;
        ddy += 2;
        err += ddy;
      end
      x++;
      ddx += 2;
      err += ddx;
      off_r = {off_r, x, -x, x, -x};
      off_c = {off_c, y, y, -y, -y};
      if (x != y) begin
        off_r = {off_r, y, -y, y, -y};
        off_c = {off_c, x, x, -x, -x};
      end
    end
    for (int r = 0; r < nr; r++) begin
      for (int c = 0; c < nc; c++) begin
        v = cell_written[r*SIDE+c] ? grid_src[r*SIDE+c] : 8'sd0;
        if (v == FREE) continue;
        foreach (off_r[k]) begin
          tr = r + off_r[k];
          tc = c + off_c[k];
          if (tr >= 0 && tr < nr && tc >= 0 && tc < nc) begin
            t = tr * SIDE + tc;
            if (v > grid_dil[t]) grid_dil[t] = v;
          end
        end
      end
    end
  endtask

  // One input transfer; called and returning just after a falling edge.
  task automatic send_item(op_t op, logic [5:0] row, logic [5:0] col,
                           logic signed [7:0] value, bit known, logic signed [7:0] want);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_op         <= op;
    in_row        <= row;
    in_col        <= col;
    in_cell_value <= value;
    do @(posedge clk); while (in_stall);
    case (op)
      OP_WRITE: begin
        grid_src[row*SIDE+col]     = value;
        cell_written[row*SIDE+col] = 1'b1;
      end
      OP_RUN: dilate_grid();
      OP_READ: pending_values = {pending_values, (known ? want : grid_dil[row*SIDE+col])};
      default: ;
    endcase
    n_items++;
    @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, int unsigned data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data[CFG_W-1:0];
    @(negedge clk);
    case (idx)
      REG_ROWS:   rows_reg = data[6:0];
      REG_COLS:   cols_reg = data[6:0];
      REG_RADIUS: radius_reg = data[3:0];
      default: ;
    endcase
  endtask

  function automatic logic signed [7:0] pick_value();
    return ($urandom_range(99) < 60) ? 8'sd0 : 8'($urandom);
  endfunction

  // Configure, load every unwritten cell of the area, run, then mostly read back.
  task automatic dilation_pass(int unsigned nrow, int unsigned ncol, int unsigned rad,
                               int n_ops, bit squeeze);
    int unsigned re, ce, pick;
    logic [5:0] r, c;
    in_valid <= 1'b0;
    while (pending_values.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    write_reg(REG_ROWS, nrow);
    write_reg(REG_COLS, ncol);
    write_reg(REG_RADIUS, rad);
    cfg_we <= 1'b0;
    re = eff_rows();
    ce = eff_cols();
    for (int i = 0; i < re; i++)
      for (int j = 0; j < ce; j++)
        if (!cell_written[i*SIDE+j])
          send_item(OP_WRITE, 6'(i), 6'(j), pick_value(), 1'b0, 8'sd0);
    repeat ($urandom_range(0, 5))
      send_item(OP_WRITE, 6'($urandom), 6'($urandom), pick_value(), 1'b0, 8'sd0);
    send_item(OP_RUN, 6'($urandom), 6'($urandom), 8'($urandom), 1'b0, 8'sd0);
    // The hold-off starts once the run is over, so pending reads back up the input.
    if (squeeze) begin
      send_item(OP_READ, 6'($urandom), 6'($urandom), 8'($urandom), 1'b0, 8'sd0);
      hold_req++;
    end
    repeat (n_ops) begin
      pick = $urandom_range(99);
      if (re > 0 && ce > 0 && $urandom_range(99) < 80) begin
        r = 6'($urandom_range(0, re - 1));
        c = 6'($urandom_range(0, ce - 1));
      end else begin
        r = 6'($urandom);
        c = 6'($urandom);
      end
      if (pick < 80) send_item(OP_READ, r, c, 8'($urandom), 1'b0, 8'sd0);
      else if (pick < 92) send_item(OP_WRITE, r, c, pick_value(), 1'b0, 8'sd0);
      else if (pick < 96)
        send_item(OP_NONE, 6'($urandom), 6'($urandom), 8'($urandom), 1'b0, 8'sd0);
      else send_item(OP_RUN, 6'($urandom), 6'($urandom), 8'($urandom), 1'b0, 8'sd0);
    end
    send_item(OP_READ, 6'($urandom), 6'($urandom), 8'($urandom), 1'b0, 8'sd0);
  endtask

  initial begin
    int unsigned nr, nc;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_op         = OP_NONE;
    in_row        = '0;
    in_col        = '0;
    in_cell_value = '0;
    out_stall     = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = REG_NONE;
    cfg_data      = '0;
    errors        = 0;
    n_items       = 0;
    cycles        = 0;
    hold_req      = 0;
    hold_seen     = 0;
    hold_left     = 0;
    tx_idle_pct   = 11;
    rx_idle_pct   = 67;
    rows_reg      = 40;
    cols_reg      = 40;
    radius_reg    = 2;
    foreach (grid_dil[i]) begin
      grid_dil[i]     = 8'sd0;
      grid_src[i]     = 8'sd0;
      cell_written[i] = 1'b0;
    end
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed rows: nothing has run yet, so every read gives zero.
    foreach (dir_rows[i]) begin
      if (dir_rows[i].op == OP_READ) dir_rows[i].want = 8'sd0;
      send_item(dir_rows[i].op, dir_rows[i].row, dir_rows[i].col, dir_rows[i].value,
                dir_rows[i].known, dir_rows[i].want);
    end

    // Directed settings: zero and maximum radius, empty and oversized areas.
    dilation_pass(4, 4, 0, 12, 1'b0);
    dilation_pass(5, 6, 1, 12, 1'b0);
    dilation_pass(0, 8, 2, 6, 1'b0);
    dilation_pass(8, 0, 3, 6, 1'b0);
    dilation_pass(127, 2, 15, 20, 1'b0);
    dilation_pass(1, 64, 15, 20, 1'b0);
    dilation_pass(64, 1, 3, 20, 1'b0);
    dilation_pass(1, 1, 7, 4, 1'b0);
    dilation_pass(3, 127, 2, 20, 1'b0);

    // Random settings; the idle mix changes by item count.
    while (n_items < N_ITEMS) begin
      if (n_items < N_ITEMS / 3) begin
        tx_idle_pct = 11;
        rx_idle_pct = 67;
      end else if (n_items < 2 * N_ITEMS / 3) begin
        tx_idle_pct = 67;
        rx_idle_pct = 11;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if ($urandom_range(7) == 0) begin
        nr = $urandom_range(0, 127);
        nc = $urandom_range(0, 2);
        if ($urandom_range(1)) begin
          nc = nr;
          nr = $urandom_range(0, 2);
        end
      end else begin
        nr = $urandom_range(1, 12);
        nc = $urandom_range(1, 12);
      end
      dilation_pass(nr, nc, $urandom_range(0, 127), $urandom_range(20, 50),
                    n_items > N_ITEMS / 2 && hold_req == 0);
    end

    // Drain and finish.
    in_valid <= 1'b0;
    while (pending_values.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/gord_pkg.sv
rtl/gord_ctrl.sv
rtl/gord_dp.sv
rtl/grid_obstacle_ring_dilation_core.sv
test/testbench.sv
